@@ design/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default number of fraction bits of the fixed-point fields
  localparam int unsigned FRAC_BITS_DEF = 14;
  // width of every payload field
  localparam int unsigned QW = 16;
  // width of an off-diagonal sum or difference
  localparam int unsigned DW = 17;
  // quotient bits produced by the divider
  localparam int unsigned QB = 17;
  // number of divider lanes
  localparam int unsigned LANES = 3;

  // which component carries the diagonal term
  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_e;

  // data that follows an item through the square root
  typedef struct packed {
    branch_e                 br;
    logic [LANES-1:0][DW-1:0] d;
  } side_t;

  // data that follows an item through the divider
  typedef struct packed {
    branch_e         br;
    logic [QW-1:0]   diag;
  } tail_t;

endpackage

@@ design/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq interfaces
// Matrix input channel and quaternion output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] col0_x;
  logic signed [15:0] col0_y;
  logic signed [15:0] col0_z;
  logic signed [15:0] col1_x;
  logic signed [15:0] col1_y;
  logic signed [15:0] col1_z;
  logic signed [15:0] col2_x;
  logic signed [15:0] col2_y;
  logic signed [15:0] col2_z;

  modport source (output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, input ready);
  modport sink   (input valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
                  col2_x, col2_y, col2_z, output ready);
endinterface

interface rmq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

@@ design/rmq_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt_pipe
// Integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt_pipe import rmq_pkg::*; #(
  parameter int unsigned SqW = 18
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [2*SqW-1:0] rad_i,
  output logic [SqW-1:0]   root_o
);

  localparam int unsigned RemW = SqW + 2;

  logic [RemW-1:0]  rem_q  [SqW];
  logic [SqW-1:0]   root_q [SqW];
  logic [2*SqW-1:0] rad_q  [SqW];

  for (genvar i = 0; i < SqW; i++) begin : g_stage
    logic [RemW-1:0]  prem;
    logic [SqW-1:0]   proot;
    logic [2*SqW-1:0] prad;
    logic [RemW+1:0]  t;
    logic [RemW+1:0]  trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign prem  = '0;
      assign proot = '0;
      assign prad  = rad_i;
    end else begin : g_next
      assign prem  = rem_q[i-1];
      assign proot = root_q[i-1];
      assign prad  = rad_q[i-1];
    end

    // bring down two radicand bits and try the next root bit
    assign t     = {prem, prad[2*SqW-1 -: 2]};
    assign trial = {2'b00, proot, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= prad << 2;
        rem_q[i]  <= ge ? RemW'(t - trial) : RemW'(t);
        root_q[i] <= {proot[SqW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[SqW-1];

endmodule

@@ design/rmq_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Three lanes of rounded d*ONE/s, restoring division one bit per stage,
// with saturation to the 16-bit output range.
// ----------------------------------------------------------------------------
module rmq_div_pipe import rmq_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF,
  parameter int unsigned SqW      = 18
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [LANES-1:0][DW-1:0] d_i,
  input  logic [SqW-1:0]           s_i,
  output logic [LANES-1:0][QW-1:0] q_o
);

  localparam int unsigned NW = SqW + QB + 1;

  logic [SqW-1:0] s_q [QB+1];

  // divisor travels with the item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= s_i;
      for (int k = 1; k <= QB; k++) s_q[k] <= s_q[k-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [SqW-1:0] rem_q [QB+1];
    logic [QB-1:0]  low_q [QB+1];
    logic           neg_q [QB+1];
    logic           ovf_q [QB+1];

    logic [DW-1:0]  mag;
    logic [NW-1:0]  num;
    logic [SqW:0]   hi;

    // numerator: |d| scaled up plus half the divisor for rounding
    assign mag = d_i[l][DW-1] ? DW'(-d_i[l]) : d_i[l];
    assign num = {{(NW-DW-FracBits){1'b0}}, mag, {FracBits{1'b0}}}
               + {{(NW-SqW+1){1'b0}}, s_i[SqW-1:1]};
    assign hi  = num[NW-1:QB];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0] <= hi[SqW-1:0];
        low_q[0] <= num[QB-1:0];
        neg_q[0] <= d_i[l][DW-1];
        ovf_q[0] <= (hi >= {1'b0, s_i});
      end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [SqW:0] t;
      logic         ge;
      logic [SqW:0] t2;

      assign t  = {rem_q[k-1], low_q[k-1][QB-1]};
      assign ge = (t >= {1'b0, s_q[k-1]});
      assign t2 = ge ? (t - {1'b0, s_q[k-1]}) : t;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= t2[SqW-1:0];
          low_q[k] <= {low_q[k-1][QB-2:0], ge};
          neg_q[k] <= neg_q[k-1];
          ovf_q[k] <= ovf_q[k-1];
        end
      end
    end

    // sign and saturate the quotient
    always_comb begin
      logic [QB-1:0] q;
      q = low_q[QB];
      if (neg_q[QB]) begin
        if (ovf_q[QB] || q[QB-1:QW-1] != '0) q_o[l] = {1'b1, {(QW-1){1'b0}}};
        else                                 q_o[l] = QW'(~q[QW-1:0] + 1'b1);
      end else begin
        if (ovf_q[QB] || q[QB-1:QW-1] != '0) q_o[l] = {1'b0, {(QW-1){1'b1}}};
        else                                 q_o[l] = q[QW-1:0];
      end
    end
  end

endmodule

@@ design/rotation_matrix_to_quaternion.sv @@
// Stages: one per root bit of the square root, one per quotient bit of the divider.
// Throughput: one beat per cycle; the whole pipe stalls only while the output
//   register holds a beat that is not taken.
// Reset: rst_ni clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Branch-on-largest-diagonal conversion of a Q2.14 rotation matrix to a
// unit quaternion: decode stage, square root pipe, divider pipe, output stage.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_mat_if.sink   mat_i,
  rmq_quat_if.source quat_o
);

  localparam int unsigned RB     = ((FracBits > 17) ? FracBits : 17) + 1;
  localparam int unsigned RS     = RB + 1;
  localparam int unsigned SqW    = (RB + FracBits + 4) / 2;
  localparam int unsigned DivLat = QB + 1;
  localparam int unsigned Lat    = 1 + SqW + DivLat + 1;

  logic [Lat-1:0] vld_q;
  logic           en;

  // global advance: the output register is free or being drained
  assign en           = !vld_q[Lat-1] || quat_o.ready;
  assign mat_i.ready  = en;
  assign quat_o.valid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], mat_i.valid};
    end
  end

  // decode: trace, branch, radicand, off-diagonal terms
  logic signed [RS-1:0] m00, m11, m22, trace, rsel, r, one;
  logic signed [DW-1:0] m10, m20, m01, m21, m02, m12;
  side_t                side_d;
  logic [RB-1:0]        r_d;

  always_comb begin
    m00   = RS'(mat_i.col0_x);
    m11   = RS'(mat_i.col1_y);
    m22   = RS'(mat_i.col2_z);
    m10   = DW'(mat_i.col0_y);
    m20   = DW'(mat_i.col0_z);
    m01   = DW'(mat_i.col1_x);
    m21   = DW'(mat_i.col1_z);
    m02   = DW'(mat_i.col2_x);
    m12   = DW'(mat_i.col2_y);
    one   = RS'(1) <<< FracBits;
    trace = m00 + m11 + m22;
    if (trace >= 0) begin
      side_d.br   = BR_W;
      rsel        = trace;
      side_d.d[0] = m21 - m12;
      side_d.d[1] = m02 - m20;
      side_d.d[2] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      side_d.br   = BR_X;
      rsel        = m00 - m11 - m22;
      side_d.d[0] = m21 - m12;
      side_d.d[1] = m10 + m01;
      side_d.d[2] = m02 + m20;
    end else if (m11 > m22) begin
      side_d.br   = BR_Y;
      rsel        = m11 - m00 - m22;
      side_d.d[0] = m02 - m20;
      side_d.d[1] = m10 + m01;
      side_d.d[2] = m21 + m12;
    end else begin
      side_d.br   = BR_Z;
      rsel        = m22 - m00 - m11;
      side_d.d[0] = m10 - m01;
      side_d.d[1] = m02 + m20;
      side_d.d[2] = m21 + m12;
    end
    r = rsel + one;
    // nonpositive radicand clamps to one lsb
    r_d = (r <= 0) ? RB'(1) : r[RB-1:0];
  end

  logic [RB-1:0] r_q;
  side_t         side_q [SqW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q       <= r_d;
      side_q[0] <= side_d;
      for (int k = 1; k <= SqW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // square root of r scaled by 2^(FracBits+2)
  logic [2*SqW-1:0] rad;
  logic [SqW-1:0]   s;

  assign rad = {{(2*SqW-RB-FracBits-2){1'b0}}, r_q, {(FracBits+2){1'b0}}};

  rmq_sqrt_pipe #(.SqW(SqW)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad),
    .root_o (s)
  );

  // diagonal term s/4 rounded, saturated
  logic [SqW-1:0] diag_w;
  tail_t          tail_d;
  tail_t          tail_q [DivLat];

  assign diag_w = SqW'((s + SqW'(2)) >> 2);

  always_comb begin
    tail_d.br   = side_q[SqW].br;
    tail_d.diag = (diag_w > SqW'(2**(QW-1) - 1)) ? {1'b0, {(QW-1){1'b1}}}
                                                 : diag_w[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail_d;
      for (int k = 1; k < DivLat; k++) tail_q[k] <= tail_q[k-1];
    end
  end

  logic [LANES-1:0][QW-1:0] q;

  rmq_div_pipe #(.FracBits(FracBits), .SqW(SqW)) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_q[SqW].d),
    .s_i   (s),
    .q_o   (q)
  );

  // place the lanes by branch into the output register
  logic [QW-1:0] qx_q, qy_q, qz_q, qw_q, qx_d, qy_d, qz_d, qw_d;

  always_comb begin
    case (tail_q[DivLat-1].br)
      BR_W: begin
        qw_d = tail_q[DivLat-1].diag; qx_d = q[0]; qy_d = q[1]; qz_d = q[2];
      end
      BR_X: begin
        qx_d = tail_q[DivLat-1].diag; qw_d = q[0]; qy_d = q[1]; qz_d = q[2];
      end
      BR_Y: begin
        qy_d = tail_q[DivLat-1].diag; qw_d = q[0]; qx_d = q[1]; qz_d = q[2];
      end
      default: begin
        qz_d = tail_q[DivLat-1].diag; qw_d = q[0]; qx_d = q[1]; qy_d = q[2];
      end
    endcase
  end

  logic br_w_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      qz_q   <= qz_d;
      qw_q   <= qw_d;
      br_w_q <= (tail_q[DivLat-1].br == BR_W);
    end
  end

  assign quat_o.quat_x = qx_q;
  assign quat_o.quat_y = qy_q;
  assign quat_o.quat_z = qz_q;
  assign quat_o.quat_w = qw_q;

  // a stalled pipe keeps every valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // an accepted beat enters the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mat_i.valid && mat_i.ready) |=> vld_q[0])
    else $error("accepted beat lost at the decode stage");

  // the diagonal term in w is never negative
  a_w_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quat_o.valid && br_w_q) |-> !quat_o.quat_w[QW-1])
    else $error("negative w on the trace branch");

endmodule
